>>> rtl/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// Shared constants for the RV32I integer execute block: widths, opcodes and
// function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rie_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_IDX_W = 5;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

endpackage

`default_nettype wire

>>> rtl/rie_ram.sv
// ----------------------------------------------------------------------------
// rie_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rie_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rv32i_integer_execute.sv
// ----------------------------------------------------------------------------
// rv32i_integer_execute
// The register file is read and the instruction word registered at transfer;
// execution then loads the output register once it is empty or being read.
// Throughput: one instruction per cycle unless the output stalls, limited by
// the single execute stage writing back the register file.
// Reset clears the pipeline, register-file valid bits (all registers read zero)
// and sets the program counter to zero; a config write reloads the counter.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_integer_execute #(
  parameter int unsigned RegCount = rie_pkg::REG_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] start_address_i,
  // instruction input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] instruction_word_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      instruction_address_o,
  output logic [4:0]       dest_index_o,
  output logic [31:0]      write_value_o,
  output logic             write_enable_o,
  output logic [31:0]      next_address_o,
  output logic             branch_taken_o,
  output logic             unknown_instruction_o
);

  localparam int unsigned XLEN  = rie_pkg::XLEN;
  localparam int unsigned IdxW  = rie_pkg::REG_IDX_W;
  localparam int unsigned AddrW = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam logic [IdxW:0] RegCountW = (IdxW+1)'(RegCount);

  // --------------------------------------------------------------------------
  // handshake
  logic in_xfer, s1_adv;
  logic s1_valid_q;
  logic [XLEN-1:0] s1_word_q;
  logic out_valid_q;

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // register file: two copies for two read ports, written together
  logic            rf_we;
  logic [IdxW-1:0] rf_waddr;
  logic [XLEN-1:0] rf_wdata;
  logic [XLEN-1:0] rs1_ram, rs2_ram;

  rie_ram #(.Width(XLEN), .Depth(RegCount)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr[AddrW-1:0]),
    .wdata_i (rf_wdata),
    .re_i    (in_xfer),
    .raddr_i (instruction_word_i[15 +: AddrW]),
    .rdata_o (rs1_ram)
  );

  rie_ram #(.Width(XLEN), .Depth(RegCount)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr[AddrW-1:0]),
    .wdata_i (rf_wdata),
    .re_i    (in_xfer),
    .raddr_i (instruction_word_i[20 +: AddrW]),
    .rdata_o (rs2_ram)
  );

  // entry valid bits stand in for the reset clear; last write is forwarded
  // because it may land in the same cycle as the following read
  logic [RegCount-1:0] rf_valid_q;
  logic                lw_valid_q;
  logic [IdxW-1:0]     lw_addr_q;
  logic [XLEN-1:0]     lw_data_q;

  // --------------------------------------------------------------------------
  // execute stage
  logic [6:0]      opcode, f7;
  logic [2:0]      f3;
  logic [IdxW-1:0] rd, rs1, rs2;
  logic [XLEN-1:0] op_a, op_b, alu_b, i_imm, b_imm, u_imm;
  logic [XLEN-1:0] pc_q, next_pc, value, alu_out;
  logic            writes, taken, unknown, alt, we;
  logic            lt_s, lt_u;

  function automatic logic [XLEN-1:0] read_op(
    input logic [IdxW-1:0]     idx,
    input logic [XLEN-1:0]     ram,
    input logic [RegCount-1:0] valid,
    input logic                lw_v,
    input logic [IdxW-1:0]     lw_a,
    input logic [XLEN-1:0]     lw_d
  );
    logic [XLEN-1:0] r;
    r = '0;
    if (idx != '0 && {1'b0, idx} < RegCountW) begin
      if (lw_v && lw_a == idx) begin
        r = lw_d;
      end else if (valid[idx[AddrW-1:0]]) begin
        r = ram;
      end
    end
    return r;
  endfunction

  always_comb begin
    opcode = s1_word_q[6:0];
    rd     = s1_word_q[11:7];
    f3     = s1_word_q[14:12];
    rs1    = s1_word_q[19:15];
    rs2    = s1_word_q[24:20];
    f7     = s1_word_q[31:25];
    i_imm  = {{20{s1_word_q[31]}}, s1_word_q[31:20]};
    b_imm  = {{19{s1_word_q[31]}}, s1_word_q[31], s1_word_q[7], s1_word_q[30:25],
              s1_word_q[11:8], 1'b0};
    u_imm  = {s1_word_q[31:12], 12'b0};

    op_a = read_op(rs1, rs1_ram, rf_valid_q, lw_valid_q, lw_addr_q, lw_data_q);
    op_b = read_op(rs2, rs2_ram, rf_valid_q, lw_valid_q, lw_addr_q, lw_data_q);

    // immediate shifts use i_imm[4:0], which is the shamt field
    alu_b = (opcode == rie_pkg::OP_REG) ? op_b : i_imm;
    alt   = (f7 == rie_pkg::F7_ALT) &&
            ((opcode == rie_pkg::OP_REG) || (f3 == rie_pkg::F3_SR));

    lt_u = op_a < alu_b;
    lt_s = $signed(op_a) < $signed(alu_b);

    unique case (f3)
      rie_pkg::F3_ADD:  alu_out = alt ? op_a - alu_b : op_a + alu_b;
      rie_pkg::F3_SLL:  alu_out = op_a << alu_b[4:0];
      rie_pkg::F3_SLT:  alu_out = {{(XLEN-1){1'b0}}, lt_s};
      rie_pkg::F3_SLTU: alu_out = {{(XLEN-1){1'b0}}, lt_u};
      rie_pkg::F3_XOR:  alu_out = op_a ^ alu_b;
      rie_pkg::F3_SR:   alu_out = alt ? XLEN'($signed(op_a) >>> alu_b[4:0])
                                      : op_a >> alu_b[4:0];
      rie_pkg::F3_OR:   alu_out = op_a | alu_b;
      rie_pkg::F3_AND:  alu_out = op_a & alu_b;
      default:          alu_out = '0;
    endcase

    writes  = 1'b0;
    taken   = 1'b0;
    unknown = 1'b0;
    value   = '0;
    next_pc = pc_q + XLEN'(4);

    priority case (opcode)
      rie_pkg::OP_REG: begin
        if (f7 == rie_pkg::F7_BASE ||
            (f7 == rie_pkg::F7_ALT && (f3 == rie_pkg::F3_ADD || f3 == rie_pkg::F3_SR))) begin
          writes = 1'b1;
          value  = alu_out;
        end else begin
          unknown = 1'b1;
        end
      end
      rie_pkg::OP_IMM: begin
        if ((f3 == rie_pkg::F3_SLL && f7 != rie_pkg::F7_BASE) ||
            (f3 == rie_pkg::F3_SR && f7 != rie_pkg::F7_BASE && f7 != rie_pkg::F7_ALT)) begin
          unknown = 1'b1;
        end else begin
          writes = 1'b1;
          value  = alu_out;
        end
      end
      rie_pkg::OP_LUI: begin
        writes = 1'b1;
        value  = u_imm;
      end
      rie_pkg::OP_AUIPC: begin
        writes = 1'b1;
        value  = pc_q + u_imm;
      end
      rie_pkg::OP_BRANCH: begin
        priority case (f3)
          rie_pkg::F3_BEQ:  taken = (op_a == op_b);
          rie_pkg::F3_BNE:  taken = (op_a != op_b);
          rie_pkg::F3_BLT:  taken = ($signed(op_a) < $signed(op_b));
          rie_pkg::F3_BGE:  taken = !($signed(op_a) < $signed(op_b));
          rie_pkg::F3_BLTU: taken = (op_a < op_b);
          rie_pkg::F3_BGEU: taken = (op_a >= op_b);
          default:          unknown = 1'b1;
        endcase
        if (taken) begin
          next_pc = pc_q + b_imm;
        end
      end
      default: unknown = 1'b1;
    endcase

    we = writes && rd != '0 && {1'b0, rd} < RegCountW;
  end

  assign rf_we    = s1_adv & we;
  assign rf_waddr = rd;
  assign rf_wdata = value;

  // --------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      rf_valid_q  <= '0;
      lw_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        pc_q <= start_address_i;
      end else if (s1_adv) begin
        pc_q <= next_pc;
      end

      if (rf_we) begin
        rf_valid_q[rd[AddrW-1:0]] <= 1'b1;
        lw_valid_q                <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_word_q <= instruction_word_i;
    end
    if (rf_we) begin
      lw_addr_q <= rd;
      lw_data_q <= value;
    end
    if (s1_adv) begin
      instruction_address_o <= pc_q;
      dest_index_o          <= writes ? rd : '0;
      write_value_o         <= writes ? value : '0;
      write_enable_o        <= we;
      next_address_o        <= next_pc;
      branch_taken_o        <= taken;
      unknown_instruction_o <= unknown;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
